// File: hdl/assert_macros.svh
// Assertion helpers included by the RTL file matrix4_multiply.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in every cycle in which the antecedent holds.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition must never hold.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// File: hdl/mm4_pkg.sv
package mm4_pkg;

    // Default matrix order and fraction width of the Q format.
    localparam int DIM_DEF       = 4;
    localparam int FRAC_BITS_DEF = 16;

    // Fixed widths of the words on the ports and of one full product.
    localparam int ELEM_W    = 32;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int POS_OUT_W = 4;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_LOAD,
        S_HOLD,
        S_ISSUE,
        S_DRAIN
    } t_state;

    // Tag that travels with each pair of operands into the multiply-accumulate.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

endpackage

// File: hdl/matrix4_multiply.sv
// Fixed-point product of two DIM x DIM matrices in signed Q16.16.
// Input channel (i_element, i_in_valid, o_in_ready): each accepted word is one
// element; the first DIM*DIM words fill the left matrix in row-major order and
// the next DIM*DIM words fill the right matrix. The input stays ready while
// loading. The word that completes the right matrix starts the computation.
// Output channel (o_product, o_position, o_last, o_out_valid, i_out_ready):
// DIM*DIM product words in row-major order, each with its row-major index and
// with o_last set on the final one.
// One shared multiply-accumulate walks the dot products, one term per cycle.
// Each product word goes through a start step, DIM operand reads from the
// stores, then the multiply, the accumulate and the saturation of the final
// term into the output register.
// The input is not ready while the product is computed; it becomes ready
// again as soon as the final product word sits in the output register.
// If the receiver stalls, the sequencer waits with the next element until the
// output register has been emptied, so no word is lost or overwritten.
// Reset clears the load count and all control state; the stores are undefined.
`include "assert_macros.svh"

module matrix4_multiply import mm4_pkg::*; #(
    parameter int DIM       = DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic signed [ELEM_W-1:0]    i_element,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    output logic signed [ELEM_W-1:0]    o_product,
    output logic [POS_OUT_W-1:0]        o_position,
    output logic                        o_last,
    output logic                        o_out_valid,
    input  logic                        i_out_ready
);

    localparam int CELLS     = DIM * DIM;
    localparam int IDX_W     = $clog2(DIM);
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int LOAD_W    = $clog2(2 * CELLS);
    localparam int POS_EXT_W = ADDR_W + POS_OUT_W;

    localparam logic [LOAD_W-1:0] LOAD_LAST  = LOAD_W'(2 * CELLS - 1);
    localparam logic [LOAD_W-1:0] LOAD_RIGHT = LOAD_W'(CELLS);
    localparam logic [IDX_W-1:0]  IDX_LAST   = IDX_W'(DIM - 1);
    localparam logic [ADDR_W-1:0] ADDR_STEP  = ADDR_W'(DIM);
    localparam logic [ADDR_W-1:0] ELEM_LAST  = ADDR_W'(CELLS - 1);

    // Element stores, one write and one registered read port each.
    logic signed [ELEM_W-1:0] r_left_mem  [CELLS];
    logic signed [ELEM_W-1:0] r_right_mem [CELLS];

    t_state                   r_state, n_state;
    logic [LOAD_W-1:0]        r_load_cnt, n_load_cnt;
    logic [IDX_W-1:0]         r_k, n_k;
    logic [IDX_W-1:0]         r_col, n_col;
    logic [ADDR_W-1:0]        r_row_base, n_row_base;
    logic [ADDR_W-1:0]        r_elem, n_elem;
    logic [ADDR_W-1:0]        r_a_addr, n_a_addr;
    logic [ADDR_W-1:0]        r_b_addr, n_b_addr;

    logic signed [ELEM_W-1:0] r_rd_a, r_rd_b;
    t_mac_ctl                 r_rd_ctl;

    logic                     r_out_valid;
    logic signed [ELEM_W-1:0] r_product;
    logic [POS_OUT_W-1:0]     r_out_pos;
    logic                     r_out_last;

    logic                     w_in_accept;
    logic                     w_out_accept;
    logic                     w_issue;
    logic                     w_mac_done;
    logic signed [ELEM_W-1:0] w_mac_result;
    logic [ADDR_W-1:0]        w_right_wr_addr;
    logic [POS_EXT_W-1:0]     w_pos_ext;

    assign o_in_ready      = (r_state == S_LOAD);
    assign w_in_accept     = i_in_valid && o_in_ready;
    assign w_out_accept    = r_out_valid && i_out_ready;
    assign w_right_wr_addr = ADDR_W'(r_load_cnt - LOAD_RIGHT);
    assign w_pos_ext       = POS_EXT_W'(r_elem);

    // Loading writes one store; the sequencer reads one term of each per cycle.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            if (r_load_cnt < LOAD_RIGHT) begin
                r_left_mem[r_load_cnt[ADDR_W-1:0]] <= i_element;
            end else begin
                r_right_mem[w_right_wr_addr] <= i_element;
            end
        end
        if (w_issue) begin
            r_rd_a <= r_left_mem[r_a_addr];
            r_rd_b <= r_right_mem[r_b_addr];
        end
    end

    // Sequencer and address registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_load_cnt <= '0;
            r_k        <= '0;
            r_col      <= '0;
            r_row_base <= '0;
            r_elem     <= '0;
            r_a_addr   <= '0;
            r_b_addr   <= '0;
            r_rd_ctl   <= '0;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
            r_k        <= n_k;
            r_col      <= n_col;
            r_row_base <= n_row_base;
            r_elem     <= n_elem;
            r_a_addr   <= n_a_addr;
            r_b_addr   <= n_b_addr;
            r_rd_ctl.valid <= w_issue;
            r_rd_ctl.first <= (r_k == '0);
            r_rd_ctl.last  <= (r_k == IDX_LAST);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_load_cnt = r_load_cnt;
        n_k        = r_k;
        n_col      = r_col;
        n_row_base = r_row_base;
        n_elem     = r_elem;
        n_a_addr   = r_a_addr;
        n_b_addr   = r_b_addr;
        w_issue    = 1'b0;
        case (r_state)
            S_LOAD: begin
                if (w_in_accept) begin
                    if (r_load_cnt == LOAD_LAST) begin
                        n_load_cnt = '0;
                        n_k        = '0;
                        n_col      = '0;
                        n_row_base = '0;
                        n_elem     = '0;
                        n_state    = S_HOLD;
                    end else begin
                        n_load_cnt = r_load_cnt + 1'b1;
                    end
                end
            end
            S_HOLD: begin
                // Start the next dot product only once the output word is free.
                if (!r_out_valid || w_out_accept) begin
                    n_a_addr = r_row_base;
                    n_b_addr = ADDR_W'(r_col);
                    n_k      = '0;
                    n_state  = S_ISSUE;
                end
            end
            S_ISSUE: begin
                w_issue  = 1'b1;
                n_a_addr = r_a_addr + 1'b1;
                n_b_addr = r_b_addr + ADDR_STEP;
                if (r_k == IDX_LAST) begin
                    n_k     = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_DRAIN: begin
                if (w_mac_done) begin
                    if (r_elem == ELEM_LAST) begin
                        n_state = S_LOAD;
                    end else begin
                        n_elem = r_elem + 1'b1;
                        if (r_col == IDX_LAST) begin
                            n_col      = '0;
                            n_row_base = r_row_base + ADDR_STEP;
                        end else begin
                            n_col = r_col + 1'b1;
                        end
                        n_state = S_HOLD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    mm4_mac #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_a      (r_rd_a),
        .i_b      (r_rd_b),
        .i_ctl    (r_rd_ctl),
        .o_result (w_mac_result),
        .o_done   (w_mac_done)
    );

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_mac_done) begin
            r_out_valid <= 1'b1;
        end else if (w_out_accept) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mac_done) begin
            r_product  <= w_mac_result;
            r_out_pos  <= w_pos_ext[POS_OUT_W-1:0];
            r_out_last <= (r_elem == ELEM_LAST);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_product   = r_product;
    assign o_position  = r_out_pos;
    assign o_last      = r_out_last;

    `ASSERT_IMPLIES(a_done_into_free_slot, i_clk, i_rst_n, w_mac_done, !r_out_valid, "finished dot product would overwrite a pending word")
    `ASSERT_IMPLIES(a_done_only_draining, i_clk, i_rst_n, w_mac_done, r_state == S_DRAIN, "dot product finished outside the drain phase")
    `ASSERT_IMPLIES(a_issue_with_empty_out, i_clk, i_rst_n, r_state == S_ISSUE, !r_out_valid, "operands issued while an output word is pending")
    `ASSERT_IMPLIES(a_count_idle_in_compute, i_clk, i_rst_n, r_state != S_LOAD, r_load_cnt == '0, "load count not cleared during the computation")

endmodule

// File: hdl/mm4_mac.sv
module mm4_mac import mm4_pkg::*; #(
    parameter int DIM       = DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic signed [ELEM_W-1:0] i_a,
    input  logic signed [ELEM_W-1:0] i_b,
    input  t_mac_ctl                 i_ctl,
    output logic signed [ELEM_W-1:0] o_result,
    output logic                     o_done
);

    // Room for the sum of DIM full products without overflow.
    localparam int ACC_W = PROD_W + $clog2(DIM);

    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-ELEM_W){1'b0}}, 1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W-ELEM_W){1'b1}}, 1'b1, {(ELEM_W-1){1'b0}}};

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  w_prod_ext;
    logic signed [ACC_W-1:0]  w_shifted;
    t_mac_ctl                 r_ctl;
    logic                     r_done;

    // Product stage, then accumulate stage.
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (r_ctl.valid) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl  <= '0;
            r_done <= 1'b0;
        end else begin
            r_ctl  <= i_ctl;
            r_done <= r_ctl.valid && r_ctl.last;
        end
    end

    always_comb begin
        w_prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        n_acc      = r_ctl.first ? w_prod_ext : r_acc + w_prod_ext;
    end

    // Floor shift back to the Q format, then clamp to the word range.
    always_comb begin
        w_shifted = r_acc >>> FRAC_BITS;
        if (w_shifted > SAT_HI) begin
            o_result = SAT_HI[ELEM_W-1:0];
        end else if (w_shifted < SAT_LO) begin
            o_result = SAT_LO[ELEM_W-1:0];
        end else begin
            o_result = w_shifted[ELEM_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule
